FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the escaped-name decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK_RSTN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/eud_pkg.sv
// ----------------------------------------------------------------------------
// eud_pkg
// Types, constants and character helpers for the escaped-name decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package eud_pkg;

    localparam logic [7:0] ESC_CHAR        = 8'h5F;  // underscore
    localparam logic [7:0] CASE_FOLD       = 8'h20;
    localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

    // Decode phase, one-hot
    typedef enum logic [3:0] {
        PH_PLAIN = 4'b0001,  // ordinary bytes
        PH_ESC   = 4'b0010,  // after an underscore
        PH_HEX   = 4'b0100,  // after the high hex digit
        PH_DROP  = 4'b1000   // discarding the rest of an aborted name
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       error;
        logic       last;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] nibble;
        logic       emit;
        result_t    res;
    } dec_out_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } code_t;

    function automatic logic hex_test(input logic [7:0] c);
        logic [7:0] f;
        f = c | CASE_FOLD;
        return (c >= "0" && c <= "9") || (f >= "a" && f <= "f");
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] f;
        logic [7:0] v;
        f = c | CASE_FOLD;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else begin
            v = f - "a" + {4'd0, HEX_LETTER_BASE};
        end
        return v[3:0];
    endfunction

    function automatic code_t code_letter(input logic [7:0] c);
        code_t r;
        r.hit = 1'b1;
        unique case (c)
            "_":     r.ch = "_";
            "s":     r.ch = "/";
            "i":     r.ch = "\\";
            "p":     r.ch = ".";
            "t":     r.ch = "~";
            "r":     r.ch = " ";
            "q":     r.ch = "?";
            "h":     r.ch = ":";
            "n":     r.ch = "*";
            "l":     r.ch = "+";
            default: begin
                r.hit = 1'b0;
                r.ch  = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/escaped_name_unescape_decoder.sv
// Path: a taken input beat is held in the input register, then decoded
//   into the result register.
// Throughput: one input beat per cycle, set by the one-step decode between
//   the input register and the result register; stalls only on m_tready.
// Reset: synchronous, active low; phase returns to plain, both stages empty.
// ----------------------------------------------------------------------------
// escaped_name_unescape_decoder
// Underscore-escape name decoder: one escaped byte in, zero or one byte out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module escaped_name_unescape_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input channel
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // in_last
    // result channel
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] out_error
    output logic            m_tlast    // out_last
);
    import eud_pkg::*;

    // Input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Decode state
    phase_t     phase_reg, phase_next;
    logic [3:0] nibble_reg, nibble_next;

    // Result stage
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic       s_accept;
    logic       out_free;
    logic       in_go;
    dec_out_t   dec;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // Advance the input beat into decode whenever the result stage can take it.
    assign in_go    = in_valid_reg && out_free;
    // Accept a new beat whenever the input register is empty or moving on.
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    eud_decode u_decode (
        .phase   (phase_reg),
        .nibble  (nibble_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .dec     (dec)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        nibble_next    = nibble_reg;

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (in_go) begin
            in_valid_next = 1'b0;
        end

        if (in_go) begin
            // Escape bytes mid-sequence and dropped bytes load nothing.
            out_valid_next = dec.emit;
            phase_next     = dec.phase;
            nibble_next    = dec.nibble;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_PLAIN;
            nibble_reg    <= 4'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            nibble_reg    <= nibble_next;
        end
    end

    // Payload registers: hold until the stage moves
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_go && dec.emit) begin
            out_reg <= dec.res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.error;
    assign m_tlast  = out_reg.last;

    // An error beat carries a zero byte and closes the name.
    `ASSERT_CLK_RSTN(a_err_beat_form, aclk, aresetn,
        (m_tvalid && m_tuser) |-> (m_tdata == 8'h00 && m_tlast), "error beat malformed")

    // An error on a non-final byte must send the decoder into the drop phase.
    `ASSERT_CLK_RSTN(a_err_enters_drop, aclk, aresetn,
        (in_go && dec.emit && dec.res.error && !in_last_reg) |=> (phase_reg == PH_DROP),
        "error mid-name did not enter drop phase")

    // Nothing is produced while an aborted name is being discarded.
    `ASSERT_CLK_RSTN(a_drop_silent, aclk, aresetn,
        (in_valid_reg && phase_reg == PH_DROP) |-> !dec.emit, "result emitted while dropping")

    // The result stage never fills without a decoded beat behind it.
    `ASSERT_CLK_RSTN(a_out_source, aclk, aresetn,
        ($rose(m_tvalid)) |-> $past(in_go && dec.emit), "result beat without a source")

endmodule

`default_nettype wire

FILE: rtl/eud_decode.sv
// ----------------------------------------------------------------------------
// eud_decode
// Single-step decode of one escaped byte against the current phase.
// ----------------------------------------------------------------------------
`default_nettype none

module eud_decode (
    input  wire eud_pkg::phase_t   phase,
    input  wire logic [3:0]        nibble,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output eud_pkg::dec_out_t      dec
);
    import eud_pkg::*;

    code_t code;

    assign code = code_letter(in_byte);

    always_comb begin
        dec.phase  = phase;
        dec.nibble = nibble;
        dec.emit   = 1'b0;
        dec.res    = '0;

        unique case (phase)
            PH_PLAIN: begin
                if (in_byte == ESC_CHAR) begin
                    if (in_last) begin
                        dec.emit      = 1'b1;
                        dec.res.error = 1'b1;
                        dec.res.last  = 1'b1;
                        dec.phase     = PH_PLAIN;
                    end else begin
                        dec.phase = PH_ESC;
                    end
                end else begin
                    dec.emit     = 1'b1;
                    dec.res.data = in_byte;
                    dec.res.last = in_last;
                end
            end
            PH_ESC: begin
                if (hex_test(in_byte) && !in_last) begin
                    dec.nibble = hex_value(in_byte);
                    dec.phase  = PH_HEX;
                end else if (!hex_test(in_byte) && code.hit) begin
                    dec.emit     = 1'b1;
                    dec.res.data = code.ch;
                    dec.res.last = in_last;
                    dec.phase    = PH_PLAIN;
                end else begin
                    // cut-short escape or unknown letter
                    dec.emit      = 1'b1;
                    dec.res.error = 1'b1;
                    dec.res.last  = 1'b1;
                    dec.phase     = in_last ? PH_PLAIN : PH_DROP;
                end
            end
            PH_HEX: begin
                dec.emit = 1'b1;
                if (hex_test(in_byte)) begin
                    dec.res.data = {nibble, hex_value(in_byte)};
                    dec.res.last = in_last;
                    dec.phase    = PH_PLAIN;
                end else begin
                    dec.res.error = 1'b1;
                    dec.res.last  = 1'b1;
                    dec.phase     = in_last ? PH_PLAIN : PH_DROP;
                end
            end
            PH_DROP: begin
                if (in_last) begin
                    dec.phase = PH_PLAIN;
                end
            end
            default: begin
                dec.phase = PH_PLAIN;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/escaped_name_unescape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_name_unescape_decoder_tb
// Self-checking bench for the underscore-escape name decoder. A short table
// of hand-picked names goes in first: plain bytes at both ends of the range,
// hex and code-letter escapes, and every way a name can be aborted. Random
// names follow, mostly well formed and some broken or pure noise, under four
// idle mixes. A behavioural decoder predicts each result beat, and a monitor
// compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------

module escaped_name_unescape_decoder_tb;

    import eud_pkg::*;

    // Result beat of an aborted name: no data, error and last both set
    localparam result_t NAME_ABORTED = {8'h00, 1'b1, 1'b1};
    // The ten letters that may follow an underscore on their own
    localparam logic [79:0] CODE_LETTERS = "_siptrqhnl";
    localparam int BEATS_PER_MIX = 320;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
        logic       typed;   // 1: use the result typed into the row
        result_t    want;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [7:0] in_byte
    logic       s_tlast;     // in_last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [7:0] out_byte
    logic       m_tuser;     // [0] out_error
    logic       m_tlast;     // out_last

    // Decoder state as the bench sees it
    phase_t     dec_phase = PH_PLAIN;
    logic [3:0] hi_nibble = 4'h0;

    result_t    pending_bytes [$];   // decoded bytes still to come out
    logic [7:0] name_bytes [$];      // name under construction
    stim_row_t  directed_rows [$];

    int s_idle_pct  = 0;
    int r_stall_pct = 0;
    int hold_req    = 0;
    int hold_left   = 0;
    int holds_done  = 0;

    int beats_sent   = 0;
    int names_sent   = 0;
    int bytes_seen   = 0;
    int aborts_seen  = 0;
    int fail_count   = 0;

    escaped_name_unescape_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 20 ns period: high for 10, low for 10
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // {valid, value} of a hex digit in either case
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] low;
        low = c | CASE_FOLD;
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if (low >= "a" && low <= "f")
            return {1'b1, low[3:0] + 4'd9};
        return 5'b0;
    endfunction

    // {hit, character} for a code letter after an underscore
    function automatic logic [8:0] code_char(input logic [7:0] c);
        case (c)
            "_":     return {1'b1, 8'h5F};
            "s":     return {1'b1, 8'h2F};
            "i":     return {1'b1, 8'h5C};
            "p":     return {1'b1, 8'h2E};
            "t":     return {1'b1, 8'h7E};
            "r":     return {1'b1, 8'h20};
            "q":     return {1'b1, 8'h3F};
            "h":     return {1'b1, 8'h3A};
            "n":     return {1'b1, 8'h2A};
            "l":     return {1'b1, 8'h2B};
            default: return 9'h000;
        endcase
    endfunction

    // Advance the decoder by one accepted beat; 1 when it yields a result
    function automatic logic decode_beat(input logic [7:0] b, input logic l,
                                         output result_t r);
        logic [4:0] hx;
        logic [8:0] cc;
        hx = hex_digit(b);
        cc = code_char(b);
        r  = '0;
        case (dec_phase)
            PH_PLAIN: begin
                if (b != ESC_CHAR) begin
                    r = {b, 1'b0, l};
                    return 1'b1;
                end
                if (!l) begin
                    dec_phase = PH_ESC;
                    return 1'b0;
                end
            end
            PH_ESC: begin
                if (hx[4] && !l) begin
                    hi_nibble = hx[3:0];
                    dec_phase = PH_HEX;
                    return 1'b0;
                end
                if (!hx[4] && cc[8]) begin
                    dec_phase = PH_PLAIN;
                    r = {cc[7:0], 1'b0, l};
                    return 1'b1;
                end
            end
            PH_HEX: begin
                if (hx[4]) begin
                    dec_phase = PH_PLAIN;
                    r = {hi_nibble, hx[3:0], 1'b0, l};
                    return 1'b1;
                end
            end
            default: begin
                // dropping the tail of an aborted name
                if (l)
                    dec_phase = PH_PLAIN;
                return 1'b0;
            end
        endcase
        // every path that falls through here aborts the name
        dec_phase = l ? PH_PLAIN : PH_DROP;
        r = NAME_ABORTED;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one beat; called and returns at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic l,
                             input logic typed, input result_t want);
        result_t got;
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (decode_beat(b, l, got))
            pending_bytes = {pending_bytes, typed ? want : got};
        @(negedge aclk);
    endtask

    // Hold the input quiet until every predicted byte has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_bytes.size() != 0);
    endtask

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    // Build one random name and send it, last flag on its final byte.
    // Most names are well formed; a fifth end in a broken escape, a tenth
    // are raw noise with plenty of underscores.
    task automatic send_random_name();
        int         kind;
        int         ntok;
        logic [7:0] c;
        logic [4:0] hx;
        logic [8:0] cc;
        kind = $urandom_range(99);
        if (kind < 10) begin
            ntok = $urandom_range(8, 1);
            repeat (ntok) begin
                c = $urandom_range(3) == 0 ? ESC_CHAR : 8'($urandom_range(255));
                name_bytes = {name_bytes, c};
            end
        end else begin
            ntok = (kind < 80) ? $urandom_range(6, 1) : $urandom_range(3, 0);
            repeat (ntok) begin
                case ($urandom_range(2))
                    0: begin
                        do c = 8'($urandom_range(255)); while (c == ESC_CHAR);
                        name_bytes = {name_bytes, c};
                    end
                    1: begin
                        name_bytes = {name_bytes, ESC_CHAR};
                        name_bytes = {name_bytes, random_hex_char()};
                        name_bytes = {name_bytes, random_hex_char()};
                    end
                    default: begin
                        name_bytes = {name_bytes, ESC_CHAR};
                        name_bytes = {name_bytes, CODE_LETTERS[8*$urandom_range(9) +: 8]};
                    end
                endcase
            end
            if (kind >= 80) begin
                name_bytes = {name_bytes, ESC_CHAR};
                case ($urandom_range(3))
                    0: ;    // name ends right after the underscore
                    1: name_bytes = {name_bytes, random_hex_char()};
                    2: begin
                        // unknown escape letter, then a tail to drop
                        do begin
                            c  = 8'($urandom_range(255));
                            hx = hex_digit(c);
                            cc = code_char(c);
                        end while (hx[4] || cc[8]);
                        name_bytes = {name_bytes, c};
                        repeat ($urandom_range(3))
                            name_bytes = {name_bytes, 8'($urandom_range(255))};
                    end
                    default: begin
                        // bad low digit, then a tail to drop
                        name_bytes = {name_bytes, random_hex_char()};
                        do begin
                            c  = 8'($urandom_range(255));
                            hx = hex_digit(c);
                        end while (hx[4]);
                        name_bytes = {name_bytes, c};
                        repeat ($urandom_range(3))
                            name_bytes = {name_bytes, 8'($urandom_range(255))};
                    end
                endcase
            end
        end
        foreach (name_bytes[i])
            send_beat(name_bytes[i], i == name_bytes.size() - 1, 1'b0, '0);
        names_sent++;
        name_bytes.delete();
    endtask

    function automatic void add_row(input logic [7:0] b, input logic l,
                                    input logic typed, input result_t want);
        stim_row_t row;
        row = {b, l, typed, want};
        directed_rows = {directed_rows, row};
    endfunction

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Receiver: random stalls, or a long hold-off counted here when asked
    initial begin : receiver
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_req - 1;
                hold_req  = 0;
                holds_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= r_stall_pct);
            end
        end
    end

    // Compare every result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser)
                aborts_seen++;
            else
                bytes_seen++;
            if (pending_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat at %0t: data %02h err %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.error ||
                    m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("mismatch at %0t: expected data %02h err %0b last %0b,",
                               $time, want.data, want.error, want.last);
                        $display(" got data %02h err %0b last %0b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : main_seq
        int goal;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed names; typed results where they are plain to see
        add_row("A",      1'b0, 1'b1, {8'h41, 1'b0, 1'b0});
        add_row(8'h00,    1'b0, 1'b1, {8'h00, 1'b0, 1'b0});
        add_row(8'hFF,    1'b1, 1'b1, {8'hFF, 1'b0, 1'b1});
        // escape cut short right after the underscore
        add_row(ESC_CHAR, 1'b1, 1'b1, NAME_ABORTED);
        // escape cut short after the high digit
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row("3",      1'b1, 1'b1, NAME_ABORTED);
        // unknown escape letter, then drop to the end of the name
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row("z",      1'b0, 1'b1, NAME_ABORTED);
        add_row("x",      1'b0, 1'b0, '0);
        add_row(ESC_CHAR, 1'b1, 1'b0, '0);
        // bad low digit on the last byte: straight back to plain
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row("4",      1'b0, 1'b0, '0);
        add_row("g",      1'b1, 1'b1, NAME_ABORTED);
        // hex escapes in both cases, code letters
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row("a",      1'b0, 1'b0, '0);
        add_row("F",      1'b0, 1'b0, '0);
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row("s",      1'b0, 1'b0, '0);
        add_row(ESC_CHAR, 1'b0, 1'b0, '0);
        add_row("9",      1'b0, 1'b0, '0);
        add_row("0",      1'b1, 1'b0, '0);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].b, directed_rows[i].l,
                      directed_rows[i].typed, directed_rows[i].want);
        names_sent += 6;
        wait_for_results();

        // Random names under four idle mixes, draining between them
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0:       begin s_idle_pct = 0;  r_stall_pct = 0;  end
                1:       begin s_idle_pct = 86; r_stall_pct = 0;  end
                2:       begin s_idle_pct = 0;  r_stall_pct = 86; end
                default: begin s_idle_pct = 38; r_stall_pct = 38; end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (mix == 0 || mix == 2)
                hold_req = 48;
            goal = beats_sent + BEATS_PER_MIX;
            while (beats_sent < goal)
                send_random_name();
            wait_for_results();
        end

        // let any stray result beat surface
        r_stall_pct = 0;
        repeat (8) @(negedge aclk);

        $display("run covered %0d beats in %0d names: %0d decoded bytes, %0d aborted names",
                 beats_sent, names_sent, bytes_seen, aborts_seen);
        $display("idle mixes: none, sender, receiver, both; %0d long hold-offs; %0d failures",
                 holds_done, fail_count);
        if (fail_count == 0 && pending_bytes.size() == 0) begin
            $display("escaped_name_unescape_decoder regression: pass");
        end else begin
            $display("escaped_name_unescape_decoder regression: fail");
        end
        $finish;
    end

    // Watchdog: many times the slowest clean run
    initial begin : watchdog
        #5_000_000;
        $display("escaped_name_unescape_decoder regression: fail");
        $finish;
    end

endmodule
